// ===== design/qlt_pkg.sv =====
// Shared types, character codes, lexer mode and error codes and queue sizing for the tokenizer.
package qlt_pkg;

   // Lexer modes
   localparam logic [2:0] MODE_BETWEEN    = 3'd0;
   localparam logic [2:0] MODE_PLAIN      = 3'd1;
   localparam logic [2:0] MODE_PLAIN_LATE = 3'd2;
   localparam logic [2:0] MODE_QUOTED     = 3'd3;
   localparam logic [2:0] MODE_ESCAPE     = 3'd4;
   localparam logic [2:0] MODE_AFTER_QUOT = 3'd5;
   localparam logic [2:0] MODE_SKIP       = 3'd6;

   // Error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_QUOTE_IN    = 3'd1;
   localparam logic [2:0] ERR_AT_IN       = 3'd2;
   localparam logic [2:0] ERR_JUNK_QUOTE  = 3'd3;
   localparam logic [2:0] ERR_UNCLOSED    = 3'd4;
   localparam logic [2:0] ERR_LATE_AT     = 3'd5;

   // Characters
   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;

   // Queue between front and back; depth must be a power of two
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic       has_char;
      logic [7:0] token_char;
      logic       token_end;
      logic       token_quoted;
      logic [2:0] error_code;
   } res_type;

   // One byte's worth of results: one or two words
   typedef struct packed {
      logic    two;
      res_type r0;
      res_type r1;
   } entry_type;

   function automatic res_type mk_res(input logic has, input logic [7:0] ch,
                                      input logic fin, input logic quo,
                                      input logic [2:0] err);
      res_type r;
      r.has_char     = has;
      r.token_char   = ch;
      r.token_end    = fin;
      r.token_quoted = quo;
      r.error_code   = err;
      return r;
   endfunction

endpackage

// ===== design/qlt_front.sv =====
// Front end: lexer state machine, classifies each byte into zero to two result words.
module qlt_front import qlt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] char_byte,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output logic       q_push,
   output entry_type  q_data
);

   logic [2:0] mode_ff, mode_in;
   logic       piece_ff, piece_in;
   logic       seen_ff, seen_in;
   logic       split_ff, split_in;

   logic       ws, is_op, is_at, is_paren;
   res_type    r0, r1;
   logic [1:0] n;

   assign ws       = (char_byte == CH_SPACE) ||
                     (char_byte >= CH_TAB && char_byte <= CH_CR);
   assign is_op    = (char_byte == CH_AMP) || (char_byte == CH_BAR) ||
                     (char_byte == CH_BANG);
   assign is_at    = (char_byte == CH_AT) || (char_byte == CH_PERCENT);
   assign is_paren = (char_byte == CH_LPAREN) || (char_byte == CH_RPAREN);

   always_comb begin
      mode_in  = mode_ff;
      piece_in = piece_ff;
      seen_in  = seen_ff;
      split_in = csr_wr_en ? csr_wr_data : split_ff;
      r0 = '0;
      r1 = '0;
      n  = 2'd0;
      if (char_byte == CH_LF) begin
         case (mode_ff)
            MODE_PLAIN: begin
               if (piece_ff) begin
                  r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                  n  = 2'd1;
               end
            end
            MODE_PLAIN_LATE: begin
               r0 = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_LATE_AT);
               n  = 2'd1;
            end
            MODE_QUOTED, MODE_ESCAPE: begin
               r0 = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_UNCLOSED);
               n  = 2'd1;
            end
            MODE_AFTER_QUOT: begin
               r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
               n  = 2'd1;
            end
            default: ;
         endcase
         mode_in  = MODE_BETWEEN;
         piece_in = 1'b0;
         seen_in  = 1'b0;
      end else begin
         case (mode_ff)
            MODE_BETWEEN: begin
               if (ws) begin
               end else if (char_byte == CH_DQUOTE) begin
                  mode_in = MODE_QUOTED;
                  seen_in = 1'b1;
               end else if (char_byte == CH_HASH) begin
                  mode_in = MODE_SKIP;
               end else if (is_paren) begin
                  r0 = mk_res(1'b1, char_byte, 1'b1, 1'b0, ERR_NONE);
                  n  = 2'd1;
                  seen_in = 1'b1;
               end else if (split_ff && is_op) begin
                  r0 = mk_res(1'b1, char_byte, 1'b1, 1'b0, ERR_NONE);
                  n  = 2'd1;
                  mode_in  = MODE_PLAIN;
                  piece_in = 1'b0;
                  seen_in  = 1'b1;
               end else begin
                  // a later token opening with '@' or '%' is flagged at its end
                  mode_in  = (seen_ff && is_at) ? MODE_PLAIN_LATE : MODE_PLAIN;
                  seen_in  = 1'b1;
                  r0 = mk_res(1'b1, char_byte, 1'b0, 1'b0, ERR_NONE);
                  n  = 2'd1;
                  piece_in = 1'b1;
               end
            end
            MODE_PLAIN, MODE_PLAIN_LATE: begin
               if (ws || char_byte == CH_HASH) begin
                  if (mode_ff == MODE_PLAIN_LATE) begin
                     r0 = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_LATE_AT);
                     n  = 2'd1;
                     mode_in = MODE_SKIP;
                  end else begin
                     if (piece_ff) begin
                        r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                        n  = 2'd1;
                     end
                     mode_in = ws ? MODE_BETWEEN : MODE_SKIP;
                  end
                  piece_in = 1'b0;
               end else if (char_byte == CH_DQUOTE) begin
                  r0 = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_QUOTE_IN);
                  n  = 2'd1;
                  mode_in  = MODE_SKIP;
                  piece_in = 1'b0;
               end else if (is_paren) begin
                  if (mode_ff == MODE_PLAIN_LATE) begin
                     r0 = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_LATE_AT);
                     n  = 2'd1;
                     mode_in = MODE_SKIP;
                  end else if (piece_ff) begin
                     r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                     r1 = mk_res(1'b1, char_byte, 1'b1, 1'b0, ERR_NONE);
                     n  = 2'd2;
                     mode_in = MODE_BETWEEN;
                  end else begin
                     r0 = mk_res(1'b1, char_byte, 1'b1, 1'b0, ERR_NONE);
                     n  = 2'd1;
                     mode_in = MODE_BETWEEN;
                  end
                  piece_in = 1'b0;
               end else if (is_at) begin
                  r0 = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_AT_IN);
                  n  = 2'd1;
                  mode_in  = MODE_SKIP;
                  piece_in = 1'b0;
               end else if (split_ff && is_op) begin
                  if (piece_ff) begin
                     r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b0, ERR_NONE);
                     r1 = mk_res(1'b1, char_byte, 1'b1, 1'b0, ERR_NONE);
                     n  = 2'd2;
                  end else begin
                     r0 = mk_res(1'b1, char_byte, 1'b1, 1'b0, ERR_NONE);
                     n  = 2'd1;
                  end
                  piece_in = 1'b0;
               end else begin
                  r0 = mk_res(1'b1, char_byte, 1'b0, 1'b0, ERR_NONE);
                  n  = 2'd1;
                  piece_in = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (char_byte == CH_DQUOTE) begin
                  mode_in = MODE_AFTER_QUOT;
               end else if (char_byte == CH_BSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  r0 = mk_res(1'b1, char_byte, 1'b0, 1'b1, ERR_NONE);
                  n  = 2'd1;
               end
            end
            MODE_ESCAPE: begin
               // escaped quote drops its backslash
               if (char_byte != CH_DQUOTE) begin
                  r0 = mk_res(1'b1, CH_BSLASH, 1'b0, 1'b1, ERR_NONE);
                  r1 = mk_res(1'b1, char_byte, 1'b0, 1'b1, ERR_NONE);
                  n  = 2'd2;
               end else begin
                  r0 = mk_res(1'b1, char_byte, 1'b0, 1'b1, ERR_NONE);
                  n  = 2'd1;
               end
               mode_in = MODE_QUOTED;
            end
            MODE_AFTER_QUOT: begin
               if (ws) begin
                  r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
                  n  = 2'd1;
                  mode_in = MODE_BETWEEN;
               end else if (char_byte == CH_HASH) begin
                  r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
                  n  = 2'd1;
                  mode_in = MODE_SKIP;
               end else if (char_byte == CH_RPAREN) begin
                  r0 = mk_res(1'b0, 8'd0, 1'b1, 1'b1, ERR_NONE);
                  r1 = mk_res(1'b1, char_byte, 1'b1, 1'b0, ERR_NONE);
                  n  = 2'd2;
                  mode_in = MODE_BETWEEN;
               end else begin
                  r0 = mk_res(1'b0, 8'd0, 1'b0, 1'b0, ERR_JUNK_QUOTE);
                  n  = 2'd1;
                  mode_in = MODE_SKIP;
               end
               piece_in = 1'b0;
            end
            default: begin
               mode_in  = MODE_SKIP;
               piece_in = 1'b0;
            end
         endcase
      end
   end

   assign q_push    = fire && (n != 2'd0);
   assign q_data.two = (n == 2'd2);
   assign q_data.r0  = r0;
   assign q_data.r1  = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_BETWEEN;
         piece_ff <= 1'b0;
         seen_ff  <= 1'b0;
         split_ff <= 1'b1;
      end else begin
         split_ff <= split_in;
         if (fire) begin
            mode_ff  <= mode_in;
            piece_ff <= piece_in;
            seen_ff  <= seen_in;
         end
      end
   end

endmodule

// ===== design/qlt_fifo.sv =====
// Short queue of result entries between the front and back ends.
module qlt_fifo import qlt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   entry_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/qlt_back.sv =====
// Back end: unpacks queued entries into single result words behind an output register.
module qlt_back import qlt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type q_head,
   input  logic      q_empty,
   output logic      q_pop,
   input  logic      rsp_pop,
   output logic      rsp_empty,
   output res_type   rsp_word,
   output logic      rsp_last
);

   entry_type cur_ff, cur_in;
   logic      valid_ff, valid_in;
   logic      idx_ff, idx_in;
   logic      taken, done, load;

   assign taken = valid_ff && rsp_pop;
   assign done  = taken && (idx_ff || !cur_ff.two);
   assign load  = (!valid_ff || done) && !q_empty;
   assign q_pop = load;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         cur_in   = q_head;
         valid_in = 1'b1;
         idx_in   = 1'b0;
      end else if (done) begin
         valid_in = 1'b0;
         idx_in   = 1'b0;
      end else if (taken) begin
         idx_in   = 1'b1;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_word  = idx_ff ? cur_ff.r1 : cur_ff.r0;
   assign rsp_last  = idx_ff || !cur_ff.two;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== design/quoted_line_tokenizer.sv =====
// Top level of the quoted line tokenizer: front lexer, entry queue, back word unpacker.
// Path: an accepted byte's words go into the entry queue, then into the back end's output
//   register, from which they are popped.
// Throughput: one byte per cycle in while the four-entry queue has room; the back end
//   sends one word per cycle while the receiver pops, so a byte with two words holds it for both.
// Reset (synchronous): lexer between tokens, no open piece, split_operators = 1,
//   queue and output register empty.
module quoted_line_tokenizer import qlt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   // byte input, queue style
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_byte,
   // result words, queue style
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_has_char,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_end,
   output logic       rsp_token_quoted,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_of_run,
   // split_operators register
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic      fire;
   logic      q_push, q_pop, q_full, q_empty;
   entry_type q_data, q_head;
   res_type   word;

   // A byte is taken whenever the queue has room, even if it yields no word;
   // a byte with words needs one free entry, which !q_full guarantees.
   assign req_full = q_full;
   assign fire     = req_push && !q_full;

   qlt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .char_byte   (req_char_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   qlt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Output register lives in the back end; it refills from the queue, if that holds an entry,
   // in the same cycle its last word is popped.
   qlt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (word),
      .rsp_last  (rsp_last_of_run)
   );

   assign rsp_has_char     = word.has_char;
   assign rsp_token_char   = word.token_char;
   assign rsp_token_end    = word.token_end;
   assign rsp_token_quoted = word.token_quoted;
   assign rsp_error_code   = word.error_code;

endmodule

// ===== test/tb_quoted_line_tokenizer.sv =====
// Self-checking testbench for quoted_line_tokenizer: random text lines in, token words checked.
`timescale 1ns / 1ps

module tb_quoted_line_tokenizer;
   import qlt_pkg::*;

   // Run limit in cycles, set high enough for ~1750 bytes, up to two words each, a slow
   // receiver and sender gaps.
   localparam int RUN_LIMIT  = 400000;
   // Idle cycles after the last word before a register write or the end;
   // covers bytes still in the lexer that make no word.
   localparam int SETTLE     = 10;
   localparam int PHASE_SIZE = 430;

   // One expected result word plus its end-of-run mark
   typedef struct {
      res_type    w;
      logic       last;
   } tok_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_char_byte = 8'h00;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_has_char;
   logic [7:0] rsp_token_char;
   logic       rsp_token_end;
   logic       rsp_token_quoted;
   logic [2:0] rsp_error_code;
   logic       rsp_last_of_run;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   // Bytes waiting to be pushed, and words the tokenizer still owes us
   logic [7:0]   text_bytes[$];
   tok_word_type token_words[$];
   int           bytes_queued = 0;
   int           mismatches = 0;
   int           cycle_count = 0;

   // Predictor state: mirrors the lexer and the split_operators register
   logic [2:0] lex_mode;
   logic       piece_open;
   logic       token_seen;
   logic       split_ops;

   // Sender / receiver pacing
   logic       byte_taken = 1'b0;
   logic       push_n;
   int         burst_left = 0;
   int         gap_left = 0;
   int         stall_style = 0;
   int         stall_left = 0;
   int         pop_tick = 0;
   logic       pop_n;

   quoted_line_tokenizer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_char_byte    (req_char_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_has_char     (rsp_has_char),
      .rsp_token_char   (rsp_token_char),
      .rsp_token_end    (rsp_token_end),
      .rsp_token_quoted (rsp_token_quoted),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Word builders for the predictor
   // ---------------------------------------------------------------------
   function automatic res_type char_word(input logic [7:0] ch, input logic fin,
                                         input logic quo);
      return '{1'b1, ch, fin, quo, ERR_NONE};
   endfunction

   function automatic res_type end_word(input logic quo);
      return '{1'b0, 8'h00, 1'b1, quo, ERR_NONE};
   endfunction

   function automatic res_type err_word(input logic [2:0] code);
      return '{1'b0, 8'h00, 1'b0, 1'b0, code};
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: lex one byte, queue the words it produces.
   // ---------------------------------------------------------------------
   task automatic lex_byte(input logic [7:0] c);
      res_type      run[$];
      tok_word_type tw;
      logic         ws;
      logic         op;
      logic         late;
      logic         paren;
      ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
      op    = split_ops && (c == CH_AMP || c == CH_BAR || c == CH_BANG);
      late  = (lex_mode == MODE_PLAIN_LATE);
      paren = (c == CH_LPAREN) || (c == CH_RPAREN);

      if (c == CH_LF) begin
         // End of line flushes whatever token is open
         case (lex_mode)
            MODE_PLAIN:                if (piece_open) run = {run, end_word(1'b0)};
            MODE_PLAIN_LATE:           run = {run, err_word(ERR_LATE_AT)};
            MODE_QUOTED, MODE_ESCAPE:  run = {run, err_word(ERR_UNCLOSED)};
            MODE_AFTER_QUOT:           run = {run, end_word(1'b1)};
            default: begin
            end
         endcase
         lex_mode   = MODE_BETWEEN;
         piece_open = 1'b0;
         token_seen = 1'b0;
      end else begin
         case (lex_mode)
            MODE_BETWEEN: begin
               // whitespace between tokens is dropped
               if (ws) begin
               end else if (c == CH_DQUOTE) begin
                  lex_mode   = MODE_QUOTED;
                  token_seen = 1'b1;
               end else if (c == CH_HASH) begin
                  lex_mode = MODE_SKIP;
               end else if (paren) begin
                  run = {run, char_word(c, 1'b1, 1'b0)};
                  token_seen = 1'b1;
               end else if (op) begin
                  run = {run, char_word(c, 1'b1, 1'b0)};
                  lex_mode   = MODE_PLAIN;
                  piece_open = 1'b0;
                  token_seen = 1'b1;
               end else begin
                  // '@' or '%' opening a token other than the line's first
                  lex_mode = (token_seen && (c == CH_AT || c == CH_PERCENT)) ?
                             MODE_PLAIN_LATE : MODE_PLAIN;
                  token_seen = 1'b1;
                  run = {run, char_word(c, 1'b0, 1'b0)};
                  piece_open = 1'b1;
               end
            end
            MODE_PLAIN, MODE_PLAIN_LATE: begin
               if (ws || c == CH_HASH) begin
                  if (late) begin
                     run = {run, err_word(ERR_LATE_AT)};
                     lex_mode = MODE_SKIP;
                  end else begin
                     if (piece_open) run = {run, end_word(1'b0)};
                     lex_mode = ws ? MODE_BETWEEN : MODE_SKIP;
                  end
                  piece_open = 1'b0;
               end else if (c == CH_DQUOTE) begin
                  run = {run, err_word(ERR_QUOTE_IN)};
                  lex_mode   = MODE_SKIP;
                  piece_open = 1'b0;
               end else if (paren) begin
                  if (late) begin
                     run = {run, err_word(ERR_LATE_AT)};
                     lex_mode = MODE_SKIP;
                  end else begin
                     if (piece_open) run = {run, end_word(1'b0)};
                     run = {run, char_word(c, 1'b1, 1'b0)};
                     lex_mode = MODE_BETWEEN;
                  end
                  piece_open = 1'b0;
               end else if (c == CH_AT || c == CH_PERCENT) begin
                  run = {run, err_word(ERR_AT_IN)};
                  lex_mode   = MODE_SKIP;
                  piece_open = 1'b0;
               end else if (op) begin
                  // operator closes the open piece, then stands alone
                  if (piece_open) run = {run, end_word(1'b0)};
                  run = {run, char_word(c, 1'b1, 1'b0)};
                  piece_open = 1'b0;
               end else begin
                  run = {run, char_word(c, 1'b0, 1'b0)};
                  piece_open = 1'b1;
               end
            end
            MODE_QUOTED: begin
               if (c == CH_DQUOTE)      lex_mode = MODE_AFTER_QUOT;
               else if (c == CH_BSLASH) lex_mode = MODE_ESCAPE;
               else                     run = {run, char_word(c, 1'b0, 1'b1)};
            end
            MODE_ESCAPE: begin
               // only an escaped quote loses its backslash
               if (c != CH_DQUOTE) run = {run, char_word(CH_BSLASH, 1'b0, 1'b1)};
               run = {run, char_word(c, 1'b0, 1'b1)};
               lex_mode = MODE_QUOTED;
            end
            MODE_AFTER_QUOT: begin
               if (ws) begin
                  run = {run, end_word(1'b1)};
                  lex_mode = MODE_BETWEEN;
               end else if (c == CH_HASH) begin
                  run = {run, end_word(1'b1)};
                  lex_mode = MODE_SKIP;
               end else if (c == CH_RPAREN) begin
                  run = {run, end_word(1'b1)};
                  run = {run, char_word(c, 1'b1, 1'b0)};
                  lex_mode = MODE_BETWEEN;
               end else begin
                  run = {run, err_word(ERR_JUNK_QUOTE)};
                  lex_mode = MODE_SKIP;
               end
               piece_open = 1'b0;
            end
            default: begin
               lex_mode   = MODE_SKIP;
               piece_open = 1'b0;
            end
         endcase
      end

      foreach (run[i]) begin
         tw.w    = run[i];
         tw.last = (i == run.size() - 1);
         token_words = {token_words, tw};
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      tok_word_type want;
      if (reset) begin
         lex_mode   = MODE_BETWEEN;
         piece_open = 1'b0;
         token_seen = 1'b0;
         split_ops  = 1'b1;
         byte_taken <= 1'b0;
      end else begin
         if (csr_wr_en) split_ops = csr_wr_data;
         if (req_push && !req_full) lex_byte(req_char_byte);
         byte_taken <= req_push && !req_full;

         if (rsp_pop && !rsp_empty) begin
            if (token_words.size() == 0) begin
               $error("token word with none expected: char %0d err %0d",
                      rsp_token_char, rsp_error_code);
               mismatches++;
            end else begin
               want = token_words.pop_front();
               check_field("has_char",     8'(want.w.has_char),     8'(rsp_has_char));
               check_field("token_char",   want.w.token_char,       rsp_token_char);
               check_field("token_end",    8'(want.w.token_end),    8'(rsp_token_end));
               check_field("token_quoted", 8'(want.w.token_quoted), 8'(rsp_token_quoted));
               check_field("error_code",   8'(want.w.error_code),   8'(rsp_error_code));
               check_field("last_of_run",  8'(want.last),           8'(rsp_last_of_run));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: bursts of pushes with random gaps, fed from text_bytes
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      // the byte on the port went in at the last edge
      if (byte_taken) void'(text_bytes.pop_front());
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         push_n = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
         end else if (text_bytes.size() > 0) begin
            push_n = 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
         req_push <= push_n;
         if (push_n) req_char_byte <= text_bytes[0];
      end
   end

   // Receiver: random stall style, redrawn when its countdown runs out
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(16, 96);
         end else begin
            stall_left--;
         end
         case (stall_style)
            0:       pop_n = 1'b1;                       // no stalls
            1:       pop_n = 1'($urandom_range(0, 1));
            2:       pop_n = ($urandom_range(0, 3) == 0); // mostly stalled
            default: pop_n = (pop_tick % 5) < 3;          // fixed rhythm
         endcase
         pop_tick++;
         rsp_pop <= pop_n;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      text_bytes = {text_bytes, b};
      bytes_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   function automatic logic [7:0] pick_ws();
      case ($urandom_range(0, 7))
         0:       return CH_TAB;
         1:       return 8'd11;
         2:       return 8'd12;
         3:       return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   // A byte that stays inside an unquoted token (operators allowed)
   function automatic logic [7:0] word_char();
      logic [7:0] b;
      if ($urandom_range(0, 1) == 0) return 8'h61 + 8'($urandom_range(0, 25));
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_DQUOTE ||
                 b == CH_HASH || b == CH_LPAREN || b == CH_RPAREN ||
                 b == CH_AT || b == CH_PERCENT);
      return b;
   endfunction

   function automatic logic [7:0] quote_char();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CH_LF || b == CH_DQUOTE || b == CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] pick_op();
      case ($urandom_range(0, 2))
         0:       return CH_AMP;
         1:       return CH_BAR;
         default: return CH_BANG;
      endcase
   endfunction

   task automatic push_word(input int len);
      repeat (len) begin
         if ($urandom_range(0, 7) == 0) push_byte(pick_op());
         else                           push_byte(word_char());
      end
   endtask

   // Quoted body with escapes; closing quote left to the caller
   task automatic push_quoted_body();
      logic [7:0] b;
      push_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 6)) begin
         if ($urandom_range(0, 5) == 0) begin
            push_byte(CH_BSLASH);
            do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
            push_byte(b);
         end else begin
            push_byte(quote_char());
         end
      end
   endtask

   // One text line: mostly well-formed tokens, some noise and broken tokens
   task automatic gen_line();
      int n_tok;
      if ($urandom_range(0, 9) == 0) begin
         // raw noise, any byte value
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      end else begin
         n_tok = $urandom_range(1, 5);
         for (int t = 0; t < n_tok; t++) begin
            if (t > 0 || $urandom_range(0, 3) == 0) push_byte(pick_ws());
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  push_word($urandom_range(1, 6));
                  // parenthesis glued to a word
                  if ($urandom_range(0, 3) == 0)
                     push_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
               end
               3, 4: begin
                  push_quoted_body();
                  push_byte(CH_DQUOTE);
                  if ($urandom_range(0, 3) == 0) push_byte(CH_RPAREN);
               end
               5: push_byte($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
               6: push_byte(pick_op());
               7: begin
                  // '@'/'%' token, late unless it opens the line
                  push_byte($urandom_range(0, 1) ? CH_AT : CH_PERCENT);
                  push_word($urandom_range(0, 3));
               end
               8: begin
                  // quote or '@'/'%' inside a plain token
                  push_word($urandom_range(1, 3));
                  case ($urandom_range(0, 2))
                     0:       push_byte(CH_DQUOTE);
                     1:       push_byte(CH_AT);
                     default: push_byte(CH_PERCENT);
                  endcase
                  push_word($urandom_range(0, 2));
               end
               default: begin
                  push_quoted_body();
                  // unclosed quote runs to end of line
                  if ($urandom_range(0, 1) == 0) break;
                  push_byte(CH_DQUOTE);
                  case ($urandom_range(0, 2))
                     0:       push_byte(word_char());
                     1:       push_byte(CH_LPAREN);
                     default: push_byte(CH_DQUOTE);
                  endcase
               end
            endcase
         end
         if ($urandom_range(0, 4) == 0) begin
            // trailing comment, sometimes glued to the last token
            if ($urandom_range(0, 1) == 0) push_byte(pick_ws());
            push_byte(CH_HASH);
            repeat ($urandom_range(0, 8)) push_byte(quote_char());
         end
      end
      push_byte(CH_LF);
   endtask

   // Wait until every byte is in and every word is out, then settle
   task automatic drain();
      while (text_bytes.size() != 0 || req_push) @(posedge clock);
      while (token_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_split(input logic v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      int start;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, split_operators at its reset value of 1:
      // extreme byte values as a token, operators split out, paren ending a
      // token, escapes in quotes, ')' right after a closing quote, late '@'
      // token closed by end of line, unclosed quote.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_text("&b|(x)\"q\\\"\\n\")\n");
      push_text("a @c\n");
      push_text("\"u\n");
      drain();

      // Random phases, split_operators toggled between 0 and 1
      for (int phase = 0; phase < 4; phase++) begin
         write_split(phase % 2 == 1);
         start = bytes_queued;
         while (bytes_queued - start < PHASE_SIZE) gen_line();
         drain();
      end

      if (mismatches == 0 && token_words.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
